>>> rtl/core/ephs_pkg.sv
// ----------------------------------------------------------------------------
// ephs_pkg: shared types and constants of the elasto-plastic hinge step
// Field widths, fixed-point format, register indexes and transition codes.
// ----------------------------------------------------------------------------
package ephs_pkg;

	// register and field widths
	localparam int CFG_W    = 32;          // configuration write data
	localparam int YT_W     = 31;          // yield torque, stiffness, break angle
	localparam int FRAC     = 16;          // Q16.16 fraction bits
	localparam int DIVD_W   = YT_W + FRAC; // yield angle dividend (yield << 16)
	localparam int ACC_W    = DIVD_W + 1;  // elastic product accumulator
	localparam int CNT_W    = 6;           // step counter, holds DIVD_W - 1
	localparam int IDX_W    = 8;           // configuration index
	localparam int OUT_W    = 32;          // torque and increment fields

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_INIT_REST = 8'd0;
	localparam logic [IDX_W-1:0] REG_YIELD_TRQ = 8'd1;
	localparam logic [IDX_W-1:0] REG_STIFFNESS = 8'd2;
	localparam logic [IDX_W-1:0] REG_BREAK_ANG = 8'd3;

	// transition reported with each result
	typedef enum logic [1:0] {
		TR_NONE  = 2'd0,
		TR_YIELD = 2'd1,
		TR_BREAK = 2'd2
	} hinge_tr_t;

endpackage

>>> rtl/core/elastoplastic_hinge_step.sv
// ----------------------------------------------------------------------------
// elastoplastic_hinge_step: one step of an elastic, perfectly plastic hinge
// Keeps a rest angle and a latched broken flag; per angle beat it reports the
// transition, the plastic change of rest angle and the restoring torque.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          payload
//  -------   ---------  -----------------  ---------------------------------
//  s_*       in         s_tvalid/s_tready  tdata: current_angle; tuser: valid
//  m_*       out        m_tvalid/m_tready  tdata: increment, torque; tuser: tr
//  cfg_*     in         cfg_valid/ready    cfg_index, cfg_data
//
// Processing: one beat at a time. A broken, invalid, breaking or zero-stiffness
// beat goes from the check straight to the result; otherwise a shared adder
// runs a 47-step restoring divide for the yield angle, then a compare and either
// a plastic step or a 31-step shift-add multiply for the elastic torque.
// A result still stalled in the output register holds the sequencer in its
// last state. Ready is high only while idle; reset clears every register.
//
module elastoplastic_hinge_step
	import ephs_pkg::*;
#(
	parameter int ANGLE_WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	// angle beats
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [31:0]      s_tdata,   // [31:0] current_angle
	input  logic             s_tuser,   // [0] angle_valid
	// result beats
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [63:0]      m_tdata,   // [31:0] plastic_increment, [63:32] restoring_torque
	output logic [1:0]       m_tuser,   // [1:0] transition
	// register writes
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int AW = ANGLE_WIDTH;
	// width holding an angle difference against the 32-bit initial rest angle
	localparam int EW = ((AW > CFG_W) ? AW : CFG_W) + 1;
	// width of the shared adder and of offsets against the rest angle
	localparam int UW = ((AW + 2) > (DIVD_W + 2)) ? (AW + 2) : (DIVD_W + 2);

	localparam logic signed [EW-1:0] AW_HI  = EW'((64'd1 << (AW - 1)) - 64'd1);
	localparam logic signed [EW-1:0] AW_LO  = -AW_HI - EW'(1);
	localparam logic signed [UW-1:0] S32_HI = UW'(32'h7FFF_FFFF);
	localparam logic signed [UW-1:0] S32_LO = -S32_HI - UW'(1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_DIV,
		S_CMP,
		S_PLAS,
		S_MUL,
		S_TRQ,
		S_DONE
	} state_t;

	state_t                 state_q;

	// configuration and hinge state
	logic signed [31:0]     init_q;
	logic [YT_W-1:0]        yt_q;
	logic [YT_W-1:0]        stiff_q;
	logic [YT_W-1:0]        ba_q;
	logic signed [AW-1:0]   rest_q;
	logic                   broken_q;

	// working registers
	logic signed [AW-1:0]   cur_q;
	logic                   valid_q;
	logic signed [UW-1:0]   off_q;
	logic                   pos_q;
	logic [DIVD_W-1:0]      qd_q;
	logic [YT_W-1:0]        rem_q;
	logic [ACC_W-1:0]       acc_q;
	logic [CNT_W-1:0]       cnt_q;

	// result being built and output register
	hinge_tr_t              res_tr_q;
	logic [OUT_W-1:0]       res_inc_q;
	logic [OUT_W-1:0]       res_trq_q;
	hinge_tr_t              out_tr_q;
	logic [OUT_W-1:0]       out_inc_q;
	logic [OUT_W-1:0]       out_trq_q;
	logic                   m_tvalid_q;

	// combinational helpers
	logic [EW-1:0]          in_ext;
	logic signed [EW-1:0]   cur_e;
	logic signed [EW-1:0]   ini_e;
	logic signed [EW-1:0]   dev;
	logic [EW-1:0]          dev_abs;
	logic                   brk;
	logic signed [EW-1:0]   cfg_e;
	logic signed [AW-1:0]   cfg_rest;
	logic signed [UW-1:0]   cur_u;
	logic signed [UW-1:0]   rest_u;
	logic [UW-1:0]          mag;
	logic [UW-1:0]          yang_u;
	logic signed [UW-1:0]   new_rest;
	logic signed [UW-1:0]   inc;
	logic [OUT_W-1:0]       inc_sat;
	logic [OUT_W-1:0]       trq_mag;

	// shared adder
	logic [UW-1:0]          alu_a;
	logic [UW-1:0]          alu_b;
	logic                   alu_sub;
	logic [UW-1:0]          alu_y;
	logic                   no_borrow;

	logic                   s_acc;
	logic                   out_free;

	assign s_tready  = (state_q == S_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign cfg_ready = (state_q == S_IDLE);
	assign out_free  = !m_tvalid_q || m_tready;

	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {out_trq_q, out_inc_q};
	assign m_tuser   = out_tr_q;

	// low ANGLE_WIDTH bits of the zero-extended input form the signed angle
	assign in_ext = {{(EW - 32){1'b0}}, s_tdata};

	// saturate a new initial rest angle into the rest angle width
	assign cfg_e    = {{(EW - 32){cfg_data[31]}}, cfg_data};
	assign cfg_rest = (cfg_e > AW_HI) ? AW_HI[AW-1:0] :
	                  (cfg_e < AW_LO) ? AW_LO[AW-1:0] : cfg_e[AW-1:0];

	// break test: deflection from the initial rest angle
	assign cur_e   = {{(EW - AW){cur_q[AW-1]}}, cur_q};
	assign ini_e   = {{(EW - 32){init_q[31]}}, init_q};
	assign dev     = cur_e - ini_e;
	assign dev_abs = dev[EW-1] ? -dev : dev;
	assign brk     = (ba_q != '0) && (dev_abs >= EW'(ba_q));

	// offset against the current rest angle and the yield angle
	assign cur_u  = {{(UW - AW){cur_q[AW-1]}}, cur_q};
	assign rest_u = {{(UW - AW){rest_q[AW-1]}}, rest_q};
	assign mag    = off_q[UW-1] ? -off_q : off_q;
	assign yang_u = UW'(qd_q);

	// plastic flow: rest angle trails the angle by the yield angle
	assign new_rest = pos_q ? (cur_u - $signed(yang_u)) : (cur_u + $signed(yang_u));
	assign inc      = pos_q ? (off_q - $signed(yang_u)) : (off_q + $signed(yang_u));
	assign inc_sat  = (inc > S32_HI) ? S32_HI[OUT_W-1:0] :
	                  (inc < S32_LO) ? S32_LO[OUT_W-1:0] : inc[OUT_W-1:0];
	assign trq_mag  = {1'b0, yt_q};

	// one adder for both the divide and the multiply steps
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		case (state_q)
			S_DIV: begin
				alu_a   = UW'({rem_q, qd_q[DIVD_W-1]});
				alu_b   = UW'(stiff_q);
				alu_sub = 1'b1;
			end
			S_MUL: begin
				alu_a = UW'({acc_q, 1'b0});
				alu_b = stiff_q[cnt_q[4:0]] ? mag : '0;
			end
			default: begin
				alu_a   = '0;
				alu_b   = '0;
				alu_sub = 1'b0;
			end
		endcase
	end

	assign alu_y     = alu_a + (alu_sub ? ~alu_b : alu_b) + UW'(alu_sub);
	assign no_borrow = !alu_y[UW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			init_q     <= '0;
			yt_q       <= '0;
			stiff_q    <= '0;
			ba_q       <= '0;
			rest_q     <= '0;
			broken_q   <= 1'b0;
			cur_q      <= '0;
			valid_q    <= 1'b0;
			off_q      <= '0;
			pos_q      <= 1'b0;
			qd_q       <= '0;
			rem_q      <= '0;
			acc_q      <= '0;
			m_tvalid_q <= 1'b0;
			out_tr_q   <= TR_NONE;
			out_inc_q  <= '0;
			out_trq_q  <= '0;
			res_tr_q   <= TR_NONE;
			res_inc_q  <= '0;
			res_trq_q  <= '0;
			cnt_q      <= '0;
		end else begin
			// drop the result once taken, unless the next one moves in
			if (m_tvalid_q && m_tready && (state_q != S_DONE)) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						cur_q   <= in_ext[AW-1:0];
						valid_q <= s_tuser;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					res_tr_q  <= (!broken_q && valid_q && brk) ? TR_BREAK : TR_NONE;
					res_inc_q <= '0;
					res_trq_q <= '0;
					off_q     <= cur_u - rest_u;
					if (broken_q || !valid_q) begin
						state_q <= S_DONE;
					end else if (brk) begin
						broken_q <= 1'b1;
						state_q  <= S_DONE;
					end else if (stiff_q == '0) begin
						state_q <= S_DONE;
					end else begin
						// start the yield angle divide
						rem_q   <= '0;
						qd_q    <= {yt_q, {FRAC{1'b0}}};
						cnt_q   <= CNT_W'(DIVD_W - 1);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					// one quotient bit a cycle, quotient shifts in behind the dividend
					rem_q <= no_borrow ? alu_y[YT_W-1:0] : {rem_q[YT_W-2:0], qd_q[DIVD_W-1]};
					qd_q  <= {qd_q[DIVD_W-2:0], no_borrow};
					if (cnt_q == '0) begin
						state_q <= S_CMP;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				S_CMP: begin
					pos_q <= !off_q[UW-1] && (off_q != '0);
					if (mag > yang_u) begin
						state_q <= S_PLAS;
					end else begin
						acc_q   <= '0;
						cnt_q   <= CNT_W'(YT_W - 1);
						state_q <= S_MUL;
					end
				end
				S_PLAS: begin
					rest_q    <= new_rest[AW-1:0];
					res_tr_q  <= TR_YIELD;
					res_inc_q <= inc_sat;
					res_trq_q <= pos_q ? -trq_mag : trq_mag;
					state_q   <= S_DONE;
				end
				S_MUL: begin
					// stiffness bits from the top down
					acc_q <= alu_y[ACC_W-1:0];
					if (cnt_q == '0) begin
						state_q <= S_TRQ;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				S_TRQ: begin
					// elastic torque does not exceed the yield torque, no saturation
					res_trq_q <= pos_q ? -acc_q[FRAC+OUT_W-1:FRAC] : acc_q[FRAC+OUT_W-1:FRAC];
					state_q   <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (out_free) begin
						out_tr_q   <= res_tr_q;
						out_inc_q  <= res_inc_q;
						out_trq_q  <= res_trq_q;
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// register writes arrive only while idle
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_INIT_REST: begin
						init_q   <= cfg_data;
						rest_q   <= cfg_rest;
						broken_q <= 1'b0;
					end
					REG_YIELD_TRQ: yt_q    <= cfg_data[YT_W-1:0];
					REG_STIFFNESS: stiff_q <= cfg_data[YT_W-1:0];
					REG_BREAK_ANG: ba_q    <= cfg_data[YT_W-1:0];
					default: begin
						yt_q <= yt_q;
					end
				endcase
			end
		end
	end

`ifndef SYNTH
	// only a yield reports a plastic increment
	a_inc_only_on_yield: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != TR_YIELD) |-> (m_tdata[31:0] == '0))
		else $error("plastic increment without a yield");

	// one beat at a time: no acceptance right after one
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("angle beat accepted while busy");

	// broken latches until the initial rest angle is rewritten
	a_broken_latched: assert property (@(posedge clk) disable iff (!arst_n)
		broken_q && !(cfg_valid && (cfg_index == REG_INIT_REST)) |=> broken_q)
		else $error("broken flag cleared without a rest reload");

	// divide ends into the yield compare
	a_div_to_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) && (cnt_q == '0) |=> (state_q == S_CMP))
		else $error("divide did not finish into the compare");
`endif

endmodule

>>> test/hinge_step_checker.sv
// ----------------------------------------------------------------------------
// hinge_step_checker: result predictor and scoreboard for the hinge step
// Watches the angle, result and register channels, keeps its own hinge state
// and compares each result beat with the oldest predicted one.
// ----------------------------------------------------------------------------
module hinge_step_checker
	import ephs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [31:0]      s_tdata,   // [31:0] current_angle
	input  logic             s_tuser,   // [0] angle_valid
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [63:0]      m_tdata,   // [31:0] plastic_increment, [63:32] restoring_torque
	input  logic [1:0]       m_tuser,   // [1:0] transition
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output int               fail_count,
	output int               pending
);

	localparam longint SAT_HI = 64'sd2147483647;
	localparam longint SAT_LO = -64'sd2147483648;

	typedef struct packed {
		hinge_tr_t        tr;
		logic [OUT_W-1:0] inc;
		logic [OUT_W-1:0] trq;
	} hinge_result_t;

	hinge_result_t awaited_q[$];
	hinge_result_t exp_r, got_r;

	// shadow of the registers and the hinge state
	longint init_rest, rest_ang, yield_trq, stiffness, brk_ang;
	bit     broken;

	function automatic longint sat32(longint v);
		if (v > SAT_HI)
			return SAT_HI;
		if (v < SAT_LO)
			return SAT_LO;
		return v;
	endfunction

	function automatic longint mag_of(longint v);
		return v < 0 ? -v : v;
	endfunction

	// advance the shadow hinge by one angle beat and return its result
	function automatic hinge_result_t hinge_step(logic [31:0] angle, logic ok);
		longint        cur, offset, yang, prev, torque;
		hinge_result_t r;
		cur    = $signed(angle);
		torque = 0;
		r.tr   = TR_NONE;
		r.inc  = '0;
		if (!broken && ok) begin
			if (brk_ang != 0 && mag_of(cur - init_rest) >= brk_ang) begin
				broken = 1'b1;
				r.tr   = TR_BREAK;
			end else if (stiffness != 0) begin
				offset = cur - rest_ang;
				yang   = (yield_trq << FRAC) / stiffness;
				if (mag_of(offset) > yang) begin
					// plastic flow: drag the rest angle to within the yield angle
					prev     = rest_ang;
					rest_ang = offset > 0 ? cur - yang : cur + yang;
					r.inc    = OUT_W'(sat32(rest_ang - prev));
					torque   = offset > 0 ? -yield_trq : yield_trq;
					r.tr     = TR_YIELD;
				end else begin
					torque = (mag_of(offset) * stiffness) >> FRAC;
					if (offset > 0)
						torque = -torque;
				end
			end
		end
		r.trq = OUT_W'(sat32(torque));
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_rest  = 0;
			rest_ang   = 0;
			yield_trq  = 0;
			stiffness  = 0;
			brk_ang    = 0;
			broken     = 1'b0;
			awaited_q.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_r.tr  = hinge_tr_t'(m_tuser);
				got_r.inc = m_tdata[31:0];
				got_r.trq = m_tdata[63:32];
				if (awaited_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result beat: tr=%0d inc=%h trq=%h",
							got_r.tr, got_r.inc, got_r.trq);
					fail_count++;
				end else begin
					exp_r = awaited_q.pop_front();
					if (got_r.tr !== exp_r.tr || got_r.inc !== exp_r.inc ||
						got_r.trq !== exp_r.trq) begin
						if (fail_count < 10)
							$display({"result mismatch: expected tr=%0d inc=%h trq=%h,",
								" got tr=%0d inc=%h trq=%h"},
								exp_r.tr, exp_r.inc, exp_r.trq,
								got_r.tr, got_r.inc, got_r.trq);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_INIT_REST: begin
						init_rest = $signed(cfg_data);
						rest_ang  = init_rest;
						broken    = 1'b0;
					end
					REG_YIELD_TRQ: yield_trq = cfg_data[YT_W-1:0];
					REG_STIFFNESS: stiffness = cfg_data[YT_W-1:0];
					REG_BREAK_ANG: brk_ang   = cfg_data[YT_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				awaited_q.push_back(hinge_step(s_tdata, s_tuser));
			pending = awaited_q.size();
		end
	end

endmodule

>>> test/elastoplastic_hinge_step_test.sv
// ----------------------------------------------------------------------------
// elastoplastic_hinge_step_test: stimulus and verdict for the hinge step
// Drives directed and random angle beats and register writes, throttles both
// stream sides in phases, and lets the checker predict and compare results.
// ----------------------------------------------------------------------------
module elastoplastic_hinge_step_test;
	import ephs_pkg::*;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [31:0]      s_tdata;   // [31:0] current_angle
	logic             s_tuser;   // [0] angle_valid
	logic             m_tvalid;
	logic             m_tready;
	logic [63:0]      m_tdata;   // [31:0] plastic_increment, [63:32] restoring_torque
	logic [1:0]       m_tuser;   // [1:0] transition
	logic             cfg_valid;
	logic             cfg_ready;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	int fail_count;
	int pending;

	// idle odds in percent for the angle sender and the result receiver
	int send_idle;
	int recv_idle;

	elastoplastic_hinge_step #(
		.ANGLE_WIDTH(32)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	hinge_step_checker hinge_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver: stall at random on each falling edge, never when idling is off
	always @(negedge clk) begin
		m_tready <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
	end

	// whole degrees to Q16.16
	function automatic logic [31:0] q16(int d);
		return d * 65536;
	endfunction

	// present one angle beat, with random gaps first, and hold it until taken
	task automatic send_angle(logic [31:0] angle, logic ok);
		@(negedge clk);
		while (send_idle != 0 && $urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= angle;
		s_tuser  <= ok;
		do @(posedge clk); while (!s_tready);
	endtask

	// lower the angle stream and hold off until every predicted result is back
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// registers change only with the block idle
	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [31:0] center, spread, ang, val;
		int          blk, k, pick;

		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		m_tready  = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		send_idle = 38;
		recv_idle = 51;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// registers at reset: zero stiffness gives no response
		send_angle(q16(1), 1'b1);
		send_angle(32'h7FFF_FFFF, 1'b0);

		// yield angle of exactly 5 degrees, break at 90 degrees
		write_reg(REG_YIELD_TRQ, q16(10));
		write_reg(REG_STIFFNESS, q16(2));
		write_reg(REG_BREAK_ANG, q16(90));
		write_reg(REG_INIT_REST, 32'h0);
		send_angle(q16(3), 1'b1);            // elastic, negative torque
		send_angle(q16(-3), 1'b1);           // elastic, positive torque
		send_angle(q16(5), 1'b1);            // right on the yield angle: still elastic
		send_angle(q16(5) + 32'd1, 1'b1);    // one step past it: yields
		send_angle(q16(20), 1'b1);
		send_angle(q16(-20), 1'b1);
		send_angle(32'h7FFF_FFFF, 1'b0);     // invalid sample changes nothing
		send_angle(q16(89), 1'b1);
		send_angle(q16(90), 1'b1);           // deflection reaches break angle
		send_angle(q16(0), 1'b1);            // broken hinge stays silent

		// zero yield angle from the most negative rest: increments saturate
		write_reg(REG_BREAK_ANG, 32'h0);
		write_reg(REG_YIELD_TRQ, 32'h0);
		write_reg(REG_STIFFNESS, 32'h1);
		write_reg(REG_INIT_REST, 32'h8000_0000);
		send_angle(32'h7FFF_FFFF, 1'b1);
		send_angle(32'h8000_0000, 1'b1);
		send_angle(32'h8000_0000, 1'b1);     // no offset at all

		// all-ones writes: bits above the register width drop away
		write_reg(REG_YIELD_TRQ, 32'hFFFF_FFFF);
		write_reg(REG_STIFFNESS, 32'hFFFF_FFFF);
		write_reg(REG_BREAK_ANG, 32'hFFFF_FFFF);
		write_reg(REG_INIT_REST, 32'h0);
		send_angle(q16(1), 1'b1);            // largest elastic torque
		send_angle(q16(-1), 1'b1);
		send_angle(32'h8000_0000, 1'b1);     // breaks at the widest break angle

		// unknown register indexes are ignored
		write_reg(8'd4, 32'hFFFF_FFFF);
		write_reg(8'hFF, 32'h1234_5678);

		// random part: each block loads a fresh setting, then a run of angles
		// around the initial rest; idling shifts from phase to phase
		for (blk = 0; blk < 20; blk++) begin
			case (blk * 3 / 20)
				0: begin
					send_idle = 38;
					recv_idle = 51;
				end
				1: begin
					send_idle = 51;
					recv_idle = 38;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase

			case ($urandom_range(7))
				0:       val = 32'h0;
				1:       val = 32'h7FFF_FFFF;
				2:       val = $urandom();
				default: val = $urandom_range(32'h03E8_0000);
			endcase
			write_reg(REG_YIELD_TRQ, val);

			case ($urandom_range(9))
				0:       val = 32'h0;
				1:       val = 32'h1;
				2:       val = 32'h7FFF_FFFF;
				3:       val = $urandom();
				default: val = $urandom_range(32'h0064_0000, 32'h0000_1000);
			endcase
			write_reg(REG_STIFFNESS, val);

			spread = 32'd1 << $urandom_range(26, 8);
			case ($urandom_range(7))
				0:       val = 32'h1;
				1:       val = 32'h7FFF_FFFF;
				2, 3:    val = spread * $urandom_range(6, 1);
				default: val = 32'h0;
			endcase
			write_reg(REG_BREAK_ANG, val);

			if ($urandom_range(3) == 0)
				write_reg(IDX_W'($urandom_range(255, 4)), $urandom());

			case ($urandom_range(9))
				0:       center = 32'h8000_0000;
				1:       center = 32'h7FFF_FFFF;
				default: center = $urandom_range(32'h1FFF_FFFF) - 32'h1000_0000;
			endcase
			write_reg(REG_INIT_REST, center);

			for (k = 0; k < 40; k++) begin
				pick = $urandom_range(99);
				if (pick < 78)
					ang = center + $urandom_range(2 * spread) - spread;
				else if (pick < 92)
					ang = $urandom();
				else begin
					case ($urandom_range(3))
						0:       ang = 32'h7FFF_FFFF;
						1:       ang = 32'h8000_0000;
						2:       ang = 32'h0;
						default: ang = center;
					endcase
				end
				send_angle(ang, $urandom_range(99) >= 8);
				// now and then let the block run dry before the next beat
				if ($urandom_range(49) == 0)
					drain_results();
			end
		end

		drain_results();
		repeat (100) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			if (pending != 0)
				$display("%0d predicted results never arrived", pending);
			$display("*** FAILED ***");
		end
		$finish;
	end

	// hard stop well beyond the slowest correct run
	initial begin
		#20_000_000;
		$display("timeout: run did not complete");
		$display("*** FAILED ***");
		$finish;
	end

endmodule
